@@ hdl/calf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package calf_pkg;

   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_ARM_BITS = 6;
   localparam int DEF_DEPTH    = DEF_MAX_COLS * DEF_MAX_ROWS;
   localparam int DEF_ADDR_W   = $clog2(DEF_DEPTH);

   localparam int PIX_W      = 24;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int ARM_OUT_W  = 6;
   localparam int ROOM_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [8:0] RST_WIDTH      = 9'd256;
   localparam logic [8:0] RST_HEIGHT     = 9'd256;
   localparam logic [7:0] RST_NEAR_THR   = 8'd20;
   localparam logic [7:0] RST_FAR_THR    = 8'd6;
   localparam logic [5:0] RST_NEAR_LIMIT = 6'd17;
   localparam logic [5:0] RST_MAX_ARM    = 6'd34;
   localparam logic       RST_COLOR_MODE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH,
      REG_HEIGHT,
      REG_NEAR_THR,
      REG_FAR_THR,
      REG_NEAR_LIMIT,
      REG_MAX_ARM,
      REG_COLOR_MODE
   } reg_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ANCHOR,
      ST_RUN,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      DIR_LEFT,
      DIR_RIGHT,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic dir_type next_dir(input dir_type d);
      dir_type n;
      unique case (d)
         DIR_LEFT:  n = DIR_RIGHT;
         DIR_RIGHT: n = DIR_UP;
         DIR_UP:    n = DIR_DOWN;
         default:   n = DIR_LEFT;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

@@ hdl/calf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module calf_store #(
   parameter int DEPTH  = calf_pkg::DEF_DEPTH,
   parameter int ADDR_W = calf_pkg::DEF_ADDR_W
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [calf_pkg::PIX_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [calf_pkg::PIX_W-1:0] rd_data
);
   import calf_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/cross_arm_length_finder_core.sv @@
// Cross-based support region arm lengths over a stored image.
// Request channel (req_): tuser is the op, 0 stores a pixel, 1 queries the
// four arms at a pixel. A store gives no response; a store outside the
// configured size is dropped. A query gives one response on rsp_:
// left/right/up/down arms, tuser flags a position outside the size (arms
// then zero). A query first fetches the anchor, then per arm makes one
// store read per step, overlapped with the compare, and then closes the
// arm, and at last loads the output register, as the block returns to
// idle. A query outside the size goes straight to the output register.
// The single read port of the pixel store paces the arm walk. One request
// is worked at a time; req_tready is low while a query runs.
// A finished response sits in an output register, so the next request is
// taken while it waits; a stalled receiver only holds the next query at its
// end. The user must write registers through csr_ only while the block is
// idle; the block itself does not enforce it.
// Reset (synchronous) restores the register defaults and empties the output;
// the pixel store is not cleared and must be written before it is queried.
`timescale 1ns / 1ps
`default_nettype none
module cross_arm_length_finder_core #(
   parameter int MAX_COLS = calf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = calf_pkg::DEF_MAX_ROWS,
   parameter int ARM_BITS = calf_pkg::DEF_ARM_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // pixel_row, pixel_col, chan_a, chan_b, chan_c
   input  wire logic [calf_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // left_arm, right_arm, up_arm, down_arm
   output logic      [calf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bad_position
   output logic                                 rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [calf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [calf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import calf_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = ARM_BITS + 1;
   localparam int LW    = ARM_BITS + ARM_OUT_W;
   localparam int CW    = (SW > ROOM_W) ? SW : ROOM_W;
   localparam int CAP   = (1 << ARM_BITS) - 1;

   function automatic logic [AW-1:0] dir_delta(input dir_type d);
      logic [AW-1:0] v;
      unique case (d)
         DIR_LEFT:  v = '1;
         DIR_RIGHT: v = AW'(1);
         DIR_UP:    v = AW'(0) - AW'(MAX_COLS);
         default:   v = AW'(MAX_COLS);
      endcase
      return v;
   endfunction

   logic [8:0] width_ff;
   logic [8:0] height_ff;
   logic [7:0] near_thr_ff;
   logic [7:0] far_thr_ff;
   logic [5:0] near_lim_ff;
   logic [5:0] max_arm_ff;
   logic       color_mode_ff;

   state_type state_ff, state_in;
   dir_type   dir_ff, dir_in;
   logic [SW-1:0]       issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       pstep_ff, pstep_in;
   logic [AW-1:0]       nb_addr_ff, nb_addr_in;
   logic [ARM_BITS-1:0] arm_ff, arm_in;
   logic [PIX_W-1:0]    anchor_ff, anchor_in;
   logic [AW-1:0]       anchor_addr_ff;
   logic [7:0]          row_ff;
   logic [7:0]          col_ff;
   logic                bad_ff;
   logic [ARM_BITS-1:0] arm_res_ff [4];

   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tuser_ff;

   logic [7:0]       req_row;
   logic [7:0]       req_col;
   logic [PIX_W-1:0] req_pixel;
   logic [AW-1:0]    req_addr;
   logic             accept;
   logic             req_inside;
   logic [8:0]       eff_w;
   logic [8:0]       eff_h;

   logic             st_wr_en;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [PIX_W-1:0] rd_data;

   logic [7:0]          diff_a;
   logic [7:0]          diff_b;
   logic [7:0]          diff_c;
   logic [7:0]          diff_bc;
   logic [7:0]          diff_max;
   logic [7:0]          diff;
   logic [7:0]          thr;
   logic                fail;
   logic [8:0]          room_cur;
   logic [LW-1:0]       lim_ext;
   logic                issue_ok;
   logic                can_issue;
   logic                first_fail_one;
   logic [ARM_BITS-1:0] arm_new;
   logic                arm_wr;
   logic                load_out;
   logic [ARM_OUT_W-1:0] arm_out [4];

   // request fields
   assign req_row   = req_tdata[7:0];
   assign req_col   = req_tdata[15:8];
   assign req_pixel = req_tdata[39:16];
   assign req_addr  = AW'(req_row) * AW'(MAX_COLS) + AW'(req_col);

   assign eff_w = (32'(width_ff) > MAX_COLS) ? 9'(MAX_COLS) : width_ff;
   assign eff_h = (32'(height_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : height_ff;
   assign req_inside = ({1'b0, req_row} < eff_h) && ({1'b0, req_col} < eff_w);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign st_wr_en   = accept && (op_type'(req_tuser) == OP_WRITE) && req_inside;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RST_WIDTH;
         height_ff     <= RST_HEIGHT;
         near_thr_ff   <= RST_NEAR_THR;
         far_thr_ff    <= RST_FAR_THR;
         near_lim_ff   <= RST_NEAR_LIMIT;
         max_arm_ff    <= RST_MAX_ARM;
         color_mode_ff <= RST_COLOR_MODE;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_WIDTH:      width_ff      <= csr_wdata;
            REG_HEIGHT:     height_ff     <= csr_wdata;
            REG_NEAR_THR:   near_thr_ff   <= csr_wdata[7:0];
            REG_FAR_THR:    far_thr_ff    <= csr_wdata[7:0];
            REG_NEAR_LIMIT: near_lim_ff   <= csr_wdata[5:0];
            REG_MAX_ARM:    max_arm_ff    <= csr_wdata[5:0];
            REG_COLOR_MODE: color_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   calf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (req_addr),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // colour compare of the returned neighbour against the anchor
   assign diff_a   = abs_diff8(rd_data[7:0], anchor_ff[7:0]);
   assign diff_b   = abs_diff8(rd_data[15:8], anchor_ff[15:8]);
   assign diff_c   = abs_diff8(rd_data[23:16], anchor_ff[23:16]);
   assign diff_bc  = (diff_b > diff_c) ? diff_b : diff_c;
   assign diff_max = (diff_a > diff_bc) ? diff_a : diff_bc;
   assign diff     = color_mode_ff ? diff_max : diff_a;
   assign thr      = (LW'(pstep_ff) > LW'(near_lim_ff)) ? far_thr_ff : near_thr_ff;
   assign fail     = diff > thr;

   always_comb begin
      case (dir_ff)
         DIR_LEFT:  room_cur = {1'b0, col_ff};
         DIR_RIGHT: room_cur = eff_w - 9'd1 - {1'b0, col_ff};
         DIR_UP:    room_cur = {1'b0, row_ff};
         default:   room_cur = eff_h - 9'd1 - {1'b0, row_ff};
      endcase
   end

   assign lim_ext  = (LW'(max_arm_ff) > LW'(CAP)) ? LW'(CAP) : LW'(max_arm_ff);
   assign issue_ok = (LW'(issue_ff) <= lim_ext) && (CW'(issue_ff) <= CW'(room_cur));
   assign can_issue = issue_ok && !(pend_ff && fail);

   assign first_fail_one = (pstep_ff == SW'(1)) && (room_cur >= 9'd2);
   assign arm_new = !pend_ff ? arm_ff :
                    fail     ? (first_fail_one ? ARM_BITS'(1) : arm_ff) :
                               pstep_ff[ARM_BITS-1:0];

   // sequencer
   always_comb begin
      state_in   = state_ff;
      dir_in     = dir_ff;
      issue_in   = issue_ff;
      pend_in    = pend_ff;
      pstep_in   = pstep_ff;
      nb_addr_in = nb_addr_ff;
      arm_in     = arm_ff;
      anchor_in  = anchor_ff;
      rd_en      = 1'b0;
      rd_addr    = nb_addr_ff;
      arm_wr     = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op_type'(req_tuser) == OP_QUERY)) begin
               rd_en    = req_inside;
               rd_addr  = req_addr;
               state_in = req_inside ? ST_ANCHOR : ST_RESULT;
            end
         end
         ST_ANCHOR: begin
            anchor_in  = rd_data;
            dir_in     = DIR_LEFT;
            issue_in   = SW'(1);
            pend_in    = 1'b0;
            arm_in     = '0;
            nb_addr_in = anchor_addr_ff + dir_delta(DIR_LEFT);
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            arm_in = arm_new;
            if (can_issue) begin
               rd_en      = 1'b1;
               pend_in    = 1'b1;
               pstep_in   = issue_ff;
               issue_in   = issue_ff + SW'(1);
               nb_addr_in = nb_addr_ff + dir_delta(dir_ff);
            end else begin
               arm_wr     = 1'b1;
               arm_in     = '0;
               pend_in    = 1'b0;
               issue_in   = SW'(1);
               dir_in     = next_dir(dir_ff);
               nb_addr_in = anchor_addr_ff + dir_delta(next_dir(dir_ff));
               if (dir_ff == DIR_DOWN) begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff     <= dir_in;
      issue_ff   <= issue_in;
      pstep_ff   <= pstep_in;
      nb_addr_ff <= nb_addr_in;
      arm_ff     <= arm_in;
      anchor_ff  <= anchor_in;
      if (arm_wr) begin
         arm_res_ff[dir_ff] <= arm_new;
      end
      if (accept && (op_type'(req_tuser) == OP_QUERY)) begin
         row_ff         <= req_row;
         col_ff         <= req_col;
         anchor_addr_ff <= req_addr;
         bad_ff         <= !req_inside;
      end
   end

   // output register
   for (genvar d = 0; d < 4; d++) begin : g_arm_out
      assign arm_out[d] = ARM_OUT_W'({{ARM_OUT_W{1'b0}}, arm_res_ff[d]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tuser_ff <= bad_ff;
         rsp_tdata_ff <= bad_ff ? '0 : {arm_out[DIR_DOWN], arm_out[DIR_UP],
                                        arm_out[DIR_RIGHT], arm_out[DIR_LEFT]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire
